/* sv/cc20_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ChaCha20 shared definitions
// Sigma constants, block state type, register indexes and the rotate helper.
// ---------------------------------------------------------------------------
package cc20_pkg;

  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned NUM_DBL   = 10;
  localparam int unsigned DBL_STEPS = 32;
  localparam logic [CNT_W-1:0] ROUND_LAST = CNT_W'(NUM_DBL * DBL_STEPS - 1);

  localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
  localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
  localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

  typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0    = 3'd0,
    CFG_KEY_1    = 3'd1,
    CFG_KEY_2    = 3'd2,
    CFG_KEY_3    = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5
  } cfg_idx_e;

  // rotate amount follows the step within a quarter round: 16, 12, 8, 7
  function automatic logic [WORD_W-1:0] qr_rot(logic [WORD_W-1:0] x, logic [1:0] step);
    logic [WORD_W-1:0] r;
    case (step)
      2'd0:    r = {x[15:0], x[31:16]};
      2'd1:    r = {x[19:0], x[31:20]};
      2'd2:    r = {x[23:0], x[31:24]};
      default: r = {x[24:0], x[31:25]};
    endcase
    return r;
  endfunction

endpackage

/* sv/cc20_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ChaCha20 block engine
// One add/xor/rotate unit stepped over 10 double rounds, then the feed-forward
// add one word a cycle. Holds the finished keystream block for byte reads.
// ---------------------------------------------------------------------------
module cc20_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cc20_pkg::state_t init_i,
  input  logic [5:0]       ks_idx_i,
  output logic             ready_o,
  output logic [7:0]       ks_byte_o
);
  import cc20_pkg::*;

  typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_FINAL, ST_READY} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [WORD_W-1:0]  w_q [NUM_WORDS];
  logic [WORD_W-1:0]  w_d [NUM_WORDS];
  logic [WORD_W-1:0]  nw  [NUM_WORDS];
  logic [WORD_W-1:0]  rw  [NUM_WORDS];
  logic [WORD_W-1:0]  op_a, op_b, op_r, sum, mixed;
  logic [1:0]         step;
  logic               diag;

  assign step = cnt_q[1:0];
  assign diag = cnt_q[4];

  // shared unit: column 0 operands, or word 0 plus input word in the final add
  always_comb begin
    op_a = w_q[0];
    op_b = w_q[4];
    op_r = w_q[12];
    if (state_q == ST_FINAL) begin
      op_b = init_i[cnt_q[3:0]];
    end else if (step[0]) begin
      op_a = w_q[8];
      op_b = w_q[12];
      op_r = w_q[4];
    end
  end

  assign sum   = op_a + op_b;
  assign mixed = qr_rot(op_r ^ sum, step);

  // after each quarter round the rows rotate one column; at the end of a
  // round they also (un)diagonalise
  always_comb begin
    logic [1:0] amt;
    logic [1:0] col;
    amt = 2'd0;
    col = 2'd0;
    nw = w_q;
    if (step[0]) begin
      nw[8] = sum;
      nw[4] = mixed;
    end else begin
      nw[0]  = sum;
      nw[12] = mixed;
    end
    rw = nw;
    if (step == 2'd3) begin
      for (int r = 0; r < 4; r++) begin
        if (cnt_q[3:2] != 2'd3) begin
          amt = 2'd1;
        end else if (diag) begin
          amt = 2'(1 - r);
        end else begin
          amt = 2'(1 + r);
        end
        for (int j = 0; j < 4; j++) begin
          col = 2'(j) + amt;
          rw[4 * r + j] = nw[{2'(r), col}];
        end
      end
    end
  end

  always_comb begin
    w_d = w_q;
    case (state_q)
      ST_LOAD: begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          w_d[i] = init_i[i];
        end
      end
      ST_ROUND: w_d = rw;
      ST_FINAL: begin
        for (int i = 0; i < NUM_WORDS - 1; i++) begin
          w_d[i] = w_q[i + 1];
        end
        w_d[NUM_WORDS-1] = sum;
      end
      default: w_d = w_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_LOAD: begin
          state_q <= ST_ROUND;
          cnt_q   <= '0;
        end
        ST_ROUND: begin
          if (cnt_q == ROUND_LAST) begin
            state_q <= ST_FINAL;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_FINAL: begin
          if (cnt_q[3:0] == 4'hf) begin
            state_q <= ST_READY;
          end
          cnt_q <= cnt_q + 1'b1;
        end
        default: state_q <= ST_READY;
      endcase
    end
  end

  assign ready_o   = (state_q == ST_READY);
  assign ks_byte_o = w_q[ks_idx_i[5:2]][{ks_idx_i[1:0], 3'b000} +: 8];

endmodule

/* sv/chacha20_stream_cipher.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ChaCha20 byte-stream cipher
// XORs each request byte with the next keystream byte, RFC 8439 state layout.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries data_byte_i and last_in_i;
//   output channel out_valid_o / out_stall_i carries out_byte_o and last_out_o.
//   Each accepted request yields one result, registered, in the next cycle.
//   last_in_i is passed through untouched.
//   Throughput: one byte per cycle across a 64-byte keystream block while no
//   result waits under out_stall_i. After the 64th byte the block engine
//   refills: a load, 320 round steps of the shared add/xor/rotate unit and
//   16 feed-forward adds, with in_stall_o high meanwhile.
//   Reset clears key, nonce and block counter and starts block 0 at once,
//   so the first request is taken only once block 0 has been computed.
//   A write on cfg_we_i to a valid index (key parts, nonce low/high)
//   restarts the stream at block 0 with a fresh refill; writes to
//   other indexes are ignored.
//   While a result waits under out_stall_i, in_stall_o is held high.
// ---------------------------------------------------------------------------
module chacha20_stream_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cc20_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [cc20_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           last_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           last_out_o
);
  import cc20_pkg::*;

  logic [CFG_W-1:0]  key0_q, key1_q, key2_q, key3_q, nonce_lo_q;
  logic [WORD_W-1:0] nonce_hi_q;
  logic [WORD_W-1:0] blk_cnt_q;
  logic [5:0]        pos_q;
  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              cfg_hit, in_acc, blk_end, core_start, core_ready;
  logic [7:0]        ks_byte;
  state_t            init;

  always_comb begin
    case (cfg_idx_i)
      CFG_KEY_0, CFG_KEY_1, CFG_KEY_2, CFG_KEY_3,
      CFG_NONCE_LO, CFG_NONCE_HI: cfg_hit = cfg_we_i;
      default:                    cfg_hit = 1'b0;
    endcase
  end

  assign in_stall_o = !core_ready || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign blk_end    = in_acc && (pos_q == 6'd63);
  assign core_start = cfg_hit || blk_end;

  assign init[0]  = SIGMA_0;
  assign init[1]  = SIGMA_1;
  assign init[2]  = SIGMA_2;
  assign init[3]  = SIGMA_3;
  assign init[4]  = key0_q[31:0];
  assign init[5]  = key0_q[63:32];
  assign init[6]  = key1_q[31:0];
  assign init[7]  = key1_q[63:32];
  assign init[8]  = key2_q[31:0];
  assign init[9]  = key2_q[63:32];
  assign init[10] = key3_q[31:0];
  assign init[11] = key3_q[63:32];
  assign init[12] = blk_cnt_q;
  assign init[13] = nonce_lo_q[31:0];
  assign init[14] = nonce_lo_q[63:32];
  assign init[15] = nonce_hi_q;

  cc20_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (core_start),
    .init_i    (init),
    .ks_idx_i  (pos_q),
    .ready_o   (core_ready),
    .ks_byte_o (ks_byte)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q      <= '0;
      key1_q      <= '0;
      key2_q      <= '0;
      key3_q      <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      blk_cnt_q   <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_KEY_0:    key0_q     <= cfg_data_i;
          CFG_KEY_1:    key1_q     <= cfg_data_i;
          CFG_KEY_2:    key2_q     <= cfg_data_i;
          CFG_KEY_3:    key3_q     <= cfg_data_i;
          CFG_NONCE_LO: nonce_lo_q <= cfg_data_i;
          CFG_NONCE_HI: nonce_hi_q <= cfg_data_i[WORD_W-1:0];
          default:      ;
        endcase
      end
      if (cfg_hit) begin
        blk_cnt_q <= '0;
        pos_q     <= '0;
      end else if (in_acc) begin
        pos_q <= pos_q + 1'b1;
        if (blk_end) begin
          blk_cnt_q <= blk_cnt_q + 1'b1;
        end
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_byte_q <= data_byte_i ^ ks_byte;
      out_last_q <= last_in_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_out_o  = out_last_q;

endmodule

/* sv/cc20_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ChaCha20 port checker
// Port-level checks on request flow and restart behaviour, bound to the top.
// ---------------------------------------------------------------------------
module cc20_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [cc20_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i
);
  import cc20_pkg::*;

  logic cfg_valid_wr;
  assign cfg_valid_wr = cfg_we_i && (cfg_idx_i <= CFG_NONCE_HI);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no result");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken over a pending result");

  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_wr |=> in_stall_o)
    else $error("no refill after configuration write");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
